### hdl/qbs_pkg.sv
package qbs_pkg;

  // Key width and default block capacity.
  localparam int unsigned KeyW            = 16;
  localparam int unsigned MaxItemsDefault = 16;

  // One incoming request: a key and the end-of-block mark.
  typedef struct packed {
    logic [KeyW-1:0] key_value;
    logic            last_item;
  } req_t;

  // One sorted result.
  typedef struct packed {
    logic [KeyW-1:0] sorted_value;
    logic            final_result;
    logic            overflowed;
  } res_t;

  // Commands from the controller to the datapath, one per controller state.
  typedef struct packed {
    logic load;      // store the accepted key
    logic pop;       // read the top range of the stack
    logic range;     // latch the popped range and read its pivot key
    logic pivot;     // latch the pivot and start the scan
    logic rd_pair;   // read the scanned key and the key at the split edge
    logic cmp;       // compare against the pivot, first half of an exchange
    logic swap;      // second half of an exchange, advance both pointers
    logic fswap1;    // place the pivot at the split edge
    logic fswap2;    // move the displaced key to the top of the range
    logic push_r;    // push the right part if it holds two keys or more
    logic push_l;    // push the left part if it holds two keys or more
    logic out_rd;    // read the next sorted key
    logic out_emit;  // present the sorted key
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic k_at_hi;      // scan has reached the pivot position
    logic less;         // scanned key is below the pivot
    logic stack_empty;  // no range is left to partition
    logic out_final;    // the key being presented is the last of the block
  } status_t;

endpackage

### hdl/qbs_ctrl.sv
module qbs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             last_i,
  input  qbs_pkg::status_t status_i,
  output qbs_pkg::cmd_t    cmd_o,
  output logic             busy_o
);
  import qbs_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_POP    = 13'b0000000000010,
    S_RANGE  = 13'b0000000000100,
    S_PIVOT  = 13'b0000000001000,
    S_READ   = 13'b0000000010000,
    S_CMP    = 13'b0000000100000,
    S_SWAP   = 13'b0000001000000,
    S_FSWAP1 = 13'b0000010000000,
    S_FSWAP2 = 13'b0000100000000,
    S_PUSHR  = 13'b0001000000000,
    S_PUSHL  = 13'b0010000000000,
    S_OREAD  = 13'b0100000000000,
    S_OEMIT  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (accept_i && last_i) state_d = S_POP;
      S_POP:    state_d = status_i.stack_empty ? S_OREAD : S_RANGE;
      S_RANGE:  state_d = S_PIVOT;
      S_PIVOT:  state_d = S_READ;
      S_READ:   state_d = status_i.k_at_hi ? S_FSWAP1 : S_CMP;
      S_CMP:    state_d = status_i.less ? S_SWAP : S_READ;
      S_SWAP:   state_d = S_READ;
      S_FSWAP1: state_d = S_FSWAP2;
      S_FSWAP2: state_d = S_PUSHR;
      S_PUSHR:  state_d = S_PUSHL;
      S_PUSHL:  state_d = S_POP;
      S_OREAD:  state_d = S_OEMIT;
      S_OEMIT:  state_d = status_i.out_final ? S_IDLE : S_OREAD;
      default:  state_d = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Command decode.
  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = accept_i;
    cmd_o.pop      = (state_q == S_POP);
    cmd_o.range    = (state_q == S_RANGE);
    cmd_o.pivot    = (state_q == S_PIVOT);
    cmd_o.rd_pair  = (state_q == S_READ);
    cmd_o.cmp      = (state_q == S_CMP);
    cmd_o.swap     = (state_q == S_SWAP);
    cmd_o.fswap1   = (state_q == S_FSWAP1);
    cmd_o.fswap2   = (state_q == S_FSWAP2);
    cmd_o.push_r   = (state_q == S_PUSHR);
    cmd_o.push_l   = (state_q == S_PUSHL);
    cmd_o.out_rd   = (state_q == S_OREAD);
    cmd_o.out_emit = (state_q == S_OEMIT);
  end

  assign busy_o = (state_q != S_IDLE);

`ifndef NO_ASSERTIONS
  // A request is only taken while the controller is idle.
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |-> state_q == S_IDLE)
    else $error("request accepted outside idle");

  // A partition always ends by pushing its subranges and returning to the pop state.
  a_push_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PUSHL |=> state_q == S_POP)
    else $error("push sequence broken");

  // The last result of a block returns the controller to idle.
  a_final_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OEMIT && status_i.out_final) |=> state_q == S_IDLE)
    else $error("controller did not finish after the last result");
`endif

endmodule

### hdl/qbs_datapath.sv
module qbs_datapath #(
  parameter int unsigned MAX_ITEMS = qbs_pkg::MaxItemsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  qbs_pkg::req_t    req_i,
  input  qbs_pkg::cmd_t    cmd_i,
  output qbs_pkg::status_t status_o,
  output qbs_pkg::res_t    result_o
);
  import qbs_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_ITEMS);
  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned StkW = 2 * IdxW;

  // Key store and range stack, each one write port and registered reads.
  logic [KeyW-1:0] key_mem [MAX_ITEMS];
  logic [StkW-1:0] stk_mem [MAX_ITEMS];

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic [CntW-1:0] top_q, top_d;
  logic [IdxW-1:0] lo_q, hi_q, i_q, k_q, out_q;
  logic [IdxW-1:0] lo_d, hi_d, i_d, k_d, out_d;
  logic [KeyW-1:0] pivot_q;
  logic [KeyW-1:0] rd_a_q, rd_b_q;
  logic [StkW-1:0] stk_rd_q;

  logic            key_we;
  logic [IdxW-1:0] key_waddr;
  logic [KeyW-1:0] key_wdata;
  logic            rd_a_en, rd_b_en;
  logic [IdxW-1:0] rd_a_addr;
  logic            stk_we;
  logic [StkW-1:0] stk_wdata;
  logic [CntW-1:0] top_dec;

  logic            has_room;
  logic [CntW-1:0] n_new;
  logic [CntW-1:0] n_last;
  logic            push_r_ok, push_l_ok;
  logic [IdxW-1:0] stk_lo, stk_hi;

  assign has_room = (cnt_q < CntW'(MAX_ITEMS));
  assign n_new    = has_room ? cnt_q + 1'b1 : cnt_q;
  assign n_last   = n_new - 1'b1;
  assign top_dec  = top_q - 1'b1;
  assign stk_lo   = stk_rd_q[StkW-1:IdxW];
  assign stk_hi   = stk_rd_q[IdxW-1:0];

  // Subrange tests around the split point, one bit wider to avoid wrap.
  assign push_r_ok = ({1'b0, i_q} + 1'b1) < {1'b0, hi_q};
  assign push_l_ok = ({1'b0, lo_q} + 1'b1) < {1'b0, i_q};

  // Key store write port selection.
  always_comb begin
    key_we    = 1'b0;
    key_waddr = i_q;
    key_wdata = rd_a_q;
    if (cmd_i.load && has_room) begin
      key_we    = 1'b1;
      key_waddr = cnt_q[IdxW-1:0];
      key_wdata = req_i.key_value;
    end else if (cmd_i.cmp && status_o.less) begin
      key_we    = 1'b1;
      key_waddr = i_q;
      key_wdata = rd_a_q;
    end else if (cmd_i.swap) begin
      key_we    = 1'b1;
      key_waddr = k_q;
      key_wdata = rd_b_q;
    end else if (cmd_i.fswap1) begin
      key_we    = 1'b1;
      key_waddr = i_q;
      key_wdata = pivot_q;
    end else if (cmd_i.fswap2) begin
      key_we    = 1'b1;
      key_waddr = hi_q;
      key_wdata = rd_b_q;
    end
  end

  // Key store read port selection.
  always_comb begin
    rd_a_en   = cmd_i.range || cmd_i.rd_pair || cmd_i.out_rd;
    rd_b_en   = cmd_i.rd_pair;
    rd_a_addr = out_q;
    if (cmd_i.range) begin
      rd_a_addr = stk_hi;
    end else if (cmd_i.rd_pair) begin
      rd_a_addr = k_q;
    end
  end

  // Key store.
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    if (rd_a_en) begin
      rd_a_q <= key_mem[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b_q <= key_mem[i_q];
    end
  end

  // Range stack write selection: initial range, then right and left parts.
  always_comb begin
    stk_we    = 1'b0;
    stk_wdata = {lo_q, i_q - 1'b1};
    top_d     = top_q;
    if (cmd_i.load && req_i.last_item && n_new >= CntW'(2)) begin
      stk_we    = 1'b1;
      stk_wdata = {IdxW'(0), n_last[IdxW-1:0]};
      top_d     = CntW'(1);
    end else if (cmd_i.push_r && push_r_ok) begin
      stk_we    = 1'b1;
      stk_wdata = {i_q + 1'b1, hi_q};
      top_d     = top_q + 1'b1;
    end else if (cmd_i.push_l && push_l_ok) begin
      stk_we    = 1'b1;
      stk_wdata = {lo_q, i_q - 1'b1};
      top_d     = top_q + 1'b1;
    end else if (cmd_i.pop && !status_o.stack_empty) begin
      top_d     = top_dec;
    end
  end

  // Range stack.
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[top_q[IdxW-1:0]] <= stk_wdata;
    end
    if (cmd_i.pop) begin
      stk_rd_q <= stk_mem[top_dec[IdxW-1:0]];
    end
  end

  // Block count, overflow flag and output pointer.
  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    out_d = out_q;
    if (cmd_i.load) begin
      cnt_d = n_new;
      ovf_d = ovf_q || !has_room;
    end
    if (cmd_i.out_emit) begin
      if (status_o.out_final) begin
        cnt_d = '0;
        ovf_d = 1'b0;
        out_d = '0;
      end else begin
        out_d = out_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
      top_q <= '0;
      out_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
      top_q <= top_d;
      out_q <= out_d;
    end
  end

  // Partition pointers: i is the split edge, k scans the range.
  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    i_d  = i_q;
    k_d  = k_q;
    if (cmd_i.range) begin
      lo_d = stk_lo;
      hi_d = stk_hi;
    end
    if (cmd_i.pivot) begin
      i_d = lo_q;
      k_d = lo_q;
    end
    if (cmd_i.cmp && !status_o.less) begin
      k_d = k_q + 1'b1;
    end
    if (cmd_i.swap) begin
      i_d = i_q + 1'b1;
      k_d = k_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    i_q  <= i_d;
    k_q  <= k_d;
    if (cmd_i.pivot) begin
      pivot_q <= rd_a_q;
    end
  end

  // Status toward the controller.
  assign status_o.k_at_hi     = (k_q == hi_q);
  assign status_o.less        = (rd_a_q < pivot_q);
  assign status_o.stack_empty = (top_q == '0);
  assign status_o.out_final   = ((CntW'(out_q) + 1'b1) == cnt_q);

  // Result fields.
  assign result_o.sorted_value = rd_a_q;
  assign result_o.final_result = status_o.out_final;
  assign result_o.overflowed   = ovf_q;

`ifndef NO_ASSERTIONS
  // Disjoint ranges of two keys or more never fill more than half the stack.
  a_stack_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= CntW'(MAX_ITEMS / 2))
    else $error("range stack deeper than expected");

  // The stored count never exceeds the capacity.
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_ITEMS))
    else $error("stored count beyond capacity");

  // The split edge never passes the scan pointer.
  a_edge_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.cmp || cmd_i.swap) |-> i_q <= k_q)
    else $error("split edge ahead of scan pointer");

  // The last result clears the block state.
  a_block_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_emit && status_o.out_final) |=> (cnt_q == '0 && !ovf_q))
    else $error("block state not cleared after the last result");
`endif

endmodule

### hdl/quicksort_block_sorter.sv
// Loading: one request per cycle while busy is low; a key marked last starts the sort.
// Sorting: a partition reads and compares each of its non-pivot keys, then places the pivot;
// the single write port of the key store splits an exchange into two writes.
// The sort ends when the range stack is found empty. A block of one key needs no partition.
// Output: each result is read, then presented, due to the registered read of the key store;
// results cannot be stalled. Reset is asynchronous, active low, and leaves an empty block.
module quicksort_block_sorter #(
  parameter int unsigned MAX_ITEMS = qbs_pkg::MaxItemsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  qbs_pkg::req_t req_i,
  output logic          strobe_o,
  output qbs_pkg::res_t result_o
);
  import qbs_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    accept;
  logic    busy_int;

  // A request is taken while the controller is idle.
  assign accept = start && !busy_int;
  assign busy   = busy_int;

  qbs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .last_i   (req_i.last_item),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_int)
  );

  qbs_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cmd_i    (cmd),
    .status_o (status),
    .result_o (result_o)
  );

  assign strobe_o = cmd.out_emit;

endmodule
